### sv/m61_pkg.sv
// shared types, constants, microcode table and field helpers for the mod 2^61-1 alu
`default_nettype none

package m61_pkg;

   // field modulus and the exponent used for inversion
   localparam logic [60:0] FIELD_P = 61'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INV_EXP = 64'h1FFF_FFFF_FFFF_FFFD;

   // operand split points for the multiplier
   localparam int LO_W = 31;
   localparam int HI_W = 30;

   // request opcodes
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_NEG = 3'd3,
      OP_POW = 3'd4,
      OP_INV = 3'd5,
      OP_DIV = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ALU_NONE,
      ALU_ADD,
      ALU_SUB,
      ALU_NEG,
      ALU_MOVACC,
      ALU_ZERO
   } alu_op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_AB,
      MUL_ACC_BASE,
      MUL_BASE_BASE,
      MUL_A_ACC
   } mul_op_type;

   typedef enum logic [1:0] {
      DEST_RES,
      DEST_ACC,
      DEST_BASE
   } dest_type;

   typedef enum logic [2:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_E_ZERO,
      JC_E_NZ,
      JC_IS_DIV
   } jcond_type;

   // microprogram addresses
   typedef logic [3:0] step_type;

   localparam step_type S_ADD      = 4'd0;
   localparam step_type S_SUB      = 4'd1;
   localparam step_type S_NEG      = 4'd2;
   localparam step_type S_ZERO     = 4'd3;
   localparam step_type S_MUL      = 4'd4;
   localparam step_type S_MUL_WAIT = 4'd5;
   localparam step_type S_DONE     = 4'd6;
   localparam step_type S_POW      = 4'd7;
   localparam step_type S_LOOP_MUL = 4'd8;
   localparam step_type S_LOOP_SQR = 4'd9;
   localparam step_type S_LOOP_END = 4'd10;
   localparam step_type S_TAIL     = 4'd11;
   localparam step_type S_MOVACC   = 4'd12;
   localparam step_type S_DIV_MUL  = 4'd13;
   localparam step_type S_DIV_WAIT = 4'd14;

   // one control word
   typedef struct packed {
      alu_op_type alu_op;
      mul_op_type mul_op;
      logic       mul_if_bit;
      logic       shift_e;
      logic       done;
      jcond_type  jcond;
      step_type   target;
   } ucode_type;

   // decoded controls from sequencer to datapath
   typedef struct packed {
      alu_op_type alu_op;
      logic       alu_we;
      mul_op_type mul_op;
      logic       mul_go;
      logic       shift_e;
      logic       done_fire;
   } ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic e_zero;
      logic e_bit0;
      logic is_div;
      logic out_free;
   } status_type;

   function automatic ucode_type uword(
      input alu_op_type alu_op,
      input mul_op_type mul_op,
      input logic       mul_if_bit,
      input logic       shift_e,
      input logic       done,
      input jcond_type  jcond,
      input step_type   target
   );
      ucode_type w;
      w.alu_op     = alu_op;
      w.mul_op     = mul_op;
      w.mul_if_bit = mul_if_bit;
      w.shift_e    = shift_e;
      w.done       = done;
      w.jcond      = jcond;
      w.target     = target;
      return w;
   endfunction

   // microprogram rom
   function automatic ucode_type ucode_rom(input step_type pc);
      ucode_type w;
      case (pc)
         S_ADD:      w = uword(ALU_ADD, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
         S_SUB:      w = uword(ALU_SUB, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
         S_NEG:      w = uword(ALU_NEG, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
         S_ZERO:     w = uword(ALU_ZERO, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
         S_MUL:      w = uword(ALU_NONE, MUL_AB, 1'b0, 1'b0, 1'b0, JC_NEXT, S_ADD);
         S_MUL_WAIT: w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_NEXT, S_ADD);
         S_DONE:     w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b1, JC_NEXT, S_ADD);
         S_POW:      w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_E_ZERO, S_TAIL);
         S_LOOP_MUL: w = uword(ALU_NONE, MUL_ACC_BASE, 1'b1, 1'b0, 1'b0, JC_NEXT, S_ADD);
         S_LOOP_SQR: w = uword(ALU_NONE, MUL_BASE_BASE, 1'b0, 1'b1, 1'b0, JC_NEXT, S_ADD);
         S_LOOP_END: w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_E_NZ, S_LOOP_MUL);
         S_TAIL:     w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_IS_DIV, S_DIV_MUL);
         S_MOVACC:   w = uword(ALU_MOVACC, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
         S_DIV_MUL:  w = uword(ALU_NONE, MUL_A_ACC, 1'b0, 1'b0, 1'b0, JC_NEXT, S_ADD);
         S_DIV_WAIT: w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
         default:    w = uword(ALU_NONE, MUL_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS, S_DONE);
      endcase
      return w;
   endfunction

   // program entry for each opcode
   function automatic step_type entry_of(input op_type op);
      step_type s;
      case (op)
         OP_ADD:  s = S_ADD;
         OP_SUB:  s = S_SUB;
         OP_MUL:  s = S_MUL;
         OP_NEG:  s = S_NEG;
         OP_POW:  s = S_POW;
         OP_INV:  s = S_POW;
         OP_DIV:  s = S_POW;
         default: s = S_ZERO;
      endcase
      return s;
   endfunction

   // product destination for each multiply source pair
   function automatic dest_type dest_of(input mul_op_type m);
      dest_type d;
      case (m)
         MUL_ACC_BASE:  d = DEST_ACC;
         MUL_BASE_BASE: d = DEST_BASE;
         default:       d = DEST_RES;
      endcase
      return d;
   endfunction

   // modular add of two reduced values
   function automatic logic [60:0] fadd(input logic [60:0] x, input logic [60:0] y);
      logic [61:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, FIELD_P}) begin
         s = s - {1'b0, FIELD_P};
      end
      return s[60:0];
   endfunction

   // fold the one unreduced 61-bit pattern to zero
   function automatic logic [60:0] reduce_in(input logic [60:0] v);
      return (v == FIELD_P) ? '0 : v;
   endfunction

endpackage

`default_nettype wire

### sv/m61_mul.sv
// two-stage modular multiplier: partial products, then cross fold at bit 61
`default_nettype none

module m61_mul (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [60:0]       x,
   input  wire logic [60:0]       y,
   input  wire m61_pkg::dest_type dest,
   output logic                   prod_valid,
   output logic [60:0]            prod,
   output m61_pkg::dest_type      prod_dest
);

   logic [m61_pkg::LO_W-1:0] xl, yl;
   logic [m61_pkg::HI_W-1:0] xh, yh;

   logic [61:0] ll_ff, ll_in;
   logic [60:0] lh_ff, lh_in;
   logic [60:0] hl_ff, hl_in;
   logic [59:0] hh_ff, hh_in;
   logic        valid_ff;
   m61_pkg::dest_type dest_ff;

   logic [61:0] cross_sum;
   logic [63:0] sum;
   logic [61:0] fold;

   // split operands into 31-bit low and 30-bit high halves
   assign xl = x[30:0];
   assign xh = x[60:31];
   assign yl = y[30:0];
   assign yh = y[60:31];

   // four partial products
   assign ll_in = 62'(xl) * 62'(yl);
   assign lh_in = 61'(xl) * 61'(yh);
   assign hl_in = 61'(xh) * 61'(yl);
   assign hh_in = 60'(xh) * 60'(yh);

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      hh_ff   <= hh_in;
      dest_ff <= dest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= go;
      end
   end

   // combine partials using 2^61 == 1, then one end-around reduction
   always_comb begin
      cross_sum = {1'b0, lh_ff} + {1'b0, hl_ff};
      sum   = {3'b0, hh_ff, 1'b0}
            + {32'b0, cross_sum[61:30]}
            + {3'b0, cross_sum[29:0], 31'b0}
            + {2'b0, ll_ff};
      fold  = {59'b0, sum[63:61]} + {1'b0, sum[60:0]};
      if (fold >= {1'b0, m61_pkg::FIELD_P}) begin
         fold = fold - {1'b0, m61_pkg::FIELD_P};
      end
   end

   assign prod       = fold[60:0];
   assign prod_valid = valid_ff;
   assign prod_dest  = dest_ff;

endmodule

`default_nettype wire

### sv/m61_sequencer.sv
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module m61_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire m61_pkg::step_type   entry,
   input  wire m61_pkg::status_type status,
   output m61_pkg::ctrl_type        ctrl,
   output logic                     busy
);

   logic              busy_ff, busy_in;
   m61_pkg::step_type pc_ff, pc_in;
   m61_pkg::ucode_type uc;
   logic              jump;

   // control word fetch
   assign uc = m61_pkg::ucode_rom(pc_ff);

   // jump condition
   always_comb begin
      case (uc.jcond)
         m61_pkg::JC_NEXT:   jump = 1'b0;
         m61_pkg::JC_ALWAYS: jump = 1'b1;
         m61_pkg::JC_E_ZERO: jump = status.e_zero;
         m61_pkg::JC_E_NZ:   jump = !status.e_zero;
         m61_pkg::JC_IS_DIV: jump = status.is_div;
         default:            jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = entry;
         end
      end else if (uc.done) begin
         // hold on the final step until the output register is free
         if (status.out_free) begin
            busy_in = 1'b0;
         end
      end else if (jump) begin
         pc_in = uc.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   // datapath controls
   always_comb begin
      ctrl.alu_op    = uc.alu_op;
      ctrl.alu_we    = busy_ff && (uc.alu_op != m61_pkg::ALU_NONE);
      ctrl.mul_op    = uc.mul_op;
      ctrl.mul_go    = busy_ff && (uc.mul_op != m61_pkg::MUL_NONE)
                       && (!uc.mul_if_bit || status.e_bit0);
      ctrl.shift_e   = busy_ff && uc.shift_e;
      ctrl.done_fire = busy_ff && uc.done && status.out_free;
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

### sv/mersenne61_modular_alu.sv
// top level of the mod 2^61-1 arithmetic unit: operand registers, alu and handshake
//
// request channel: req_valid / req_stall carry one beat with opcode, two 61-bit
// operands and a 64-bit exponent; a beat is taken when req_valid is high and
// req_stall is low. response channel: rsp_valid / rsp_stall carry one beat with
// the reduced result for every request, in request order.
// one request is worked on at a time; req_stall is high from the accept until
// the result has been loaded into the response register, so a new request can
// be taken while the previous result still waits on a stalled response.
// the power loop spends three microcode steps per exponent bit on the single
// two-stage multiplier. a stalled response holds its beat and the final
// microcode step waits for it. reset is synchronous: it empties the response
// register and idles the sequencer; the unit takes a request in the first cycle
// after reset.
`default_nettype none

module mersenne61_modular_alu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [60:0] req_operand_a,
   input  wire logic [60:0] req_operand_b,
   input  wire logic [63:0] req_exponent,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [60:0]      rsp_result
);

   m61_pkg::ctrl_type   ctrl;
   m61_pkg::status_type status;
   m61_pkg::op_type     op;
   logic                busy;
   logic                accept;

   logic [60:0] a_ff, a_in;
   logic [60:0] acc_ff, acc_in;
   logic [60:0] base_ff, base_in;
   logic [60:0] res_ff, res_in;
   logic [63:0] e_ff, e_in;
   logic        is_div_ff, is_div_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [60:0] result_ff, result_in;

   logic [60:0]       alu_out;
   logic [60:0]       mul_x, mul_y;
   logic              prod_valid;
   logic [60:0]       prod;
   m61_pkg::dest_type prod_dest;

   assign op     = m61_pkg::op_type'(req_type);
   assign accept = req_valid && !busy;

   // sequencer status
   assign status.e_zero   = (e_ff == '0);
   assign status.e_bit0   = e_ff[0];
   assign status.is_div   = is_div_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   m61_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (req_valid),
      .entry  (m61_pkg::entry_of(op)),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // multiplier operand select
   always_comb begin
      case (ctrl.mul_op)
         m61_pkg::MUL_AB: begin
            mul_x = a_ff;
            mul_y = res_ff;
         end
         m61_pkg::MUL_ACC_BASE: begin
            mul_x = acc_ff;
            mul_y = base_ff;
         end
         m61_pkg::MUL_BASE_BASE: begin
            mul_x = base_ff;
            mul_y = base_ff;
         end
         m61_pkg::MUL_A_ACC: begin
            mul_x = a_ff;
            mul_y = acc_ff;
         end
         default: begin
            mul_x = a_ff;
            mul_y = acc_ff;
         end
      endcase
   end

   m61_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .go         (ctrl.mul_go),
      .x          (mul_x),
      .y          (mul_y),
      .dest       (m61_pkg::dest_of(ctrl.mul_op)),
      .prod_valid (prod_valid),
      .prod       (prod),
      .prod_dest  (prod_dest)
   );

   // add / subtract / negate / move / zero; operand b sits in res until it is overwritten
   always_comb begin
      case (ctrl.alu_op)
         m61_pkg::ALU_ADD:    alu_out = m61_pkg::fadd(a_ff, res_ff);
         m61_pkg::ALU_SUB:    alu_out = m61_pkg::fadd(a_ff, m61_pkg::FIELD_P - res_ff);
         m61_pkg::ALU_NEG:    alu_out = m61_pkg::fadd('0, m61_pkg::FIELD_P - a_ff);
         m61_pkg::ALU_MOVACC: alu_out = acc_ff;
         default:             alu_out = '0;
      endcase
   end

   // working registers
   always_comb begin
      a_in      = a_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      res_in    = res_ff;
      e_in      = e_ff;
      is_div_in = is_div_ff;
      if (accept) begin
         a_in      = m61_pkg::reduce_in(req_operand_a);
         res_in    = m61_pkg::reduce_in(req_operand_b);
         acc_in    = 61'd1;
         base_in   = (op == m61_pkg::OP_DIV) ? m61_pkg::reduce_in(req_operand_b)
                                             : m61_pkg::reduce_in(req_operand_a);
         e_in      = (op == m61_pkg::OP_POW) ? req_exponent : m61_pkg::INV_EXP;
         is_div_in = (op == m61_pkg::OP_DIV);
      end else begin
         if (ctrl.shift_e) begin
            e_in = {1'b0, e_ff[63:1]};
         end
         if (ctrl.alu_we) begin
            res_in = alu_out;
         end
         if (prod_valid) begin
            case (prod_dest)
               m61_pkg::DEST_ACC:  acc_in  = prod;
               m61_pkg::DEST_BASE: base_in = prod;
               m61_pkg::DEST_RES:  res_in  = prod;
               default:            res_in  = prod;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      res_ff    <= res_in;
      e_ff      <= e_in;
      is_div_ff <= is_div_in;
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.done_fire) begin
         rsp_valid_in = 1'b1;
         result_in    = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign req_stall  = busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

### sv/m61_checker.sv
// port-level checks for the mod 2^61-1 alu and their bind to the top level
`default_nettype none

module m61_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [60:0] rsp_result
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("response beat changed while stalled");

   // every result is fully reduced
   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result != m61_pkg::FIELD_P)
      else $error("response result not reduced");

   // an accepted request keeps the unit busy the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open right after an accept");

   // no result appears in the cycle right after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##1 !$rose(rsp_valid))
      else $error("response too soon after accept");

   // response channel is empty coming out of reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind mersenne61_modular_alu m61_checker u_m61_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_result (rsp_result)
);

`default_nettype wire

### dv/m61_result_checker.sv
// response checker for the mod 2^61-1 alu: predicts every result and compares rsp beats
`timescale 1ns / 100ps

module m61_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [60:0] req_operand_a,
   input  logic [60:0] req_operand_b,
   input  logic [63:0] req_exponent,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [60:0] rsp_result,
   output int          mismatch_count,
   output int          compared_count,
   output int          awaited_count
);
   import m61_pkg::*;

   // exponent that turns a power into an inverse
   localparam logic [63:0] INV_POWER = {3'b000, FIELD_P} - 64'd2;

   logic [60:0] pending_results [$];

   // the all-ones pattern is the one unreduced operand, it counts as zero
   function automatic logic [60:0] canon(input logic [60:0] v);
      return (v == FIELD_P) ? '0 : v;
   endfunction

   function automatic logic [60:0] mod_add(input logic [60:0] x, input logic [60:0] y);
      logic [61:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, FIELD_P}) begin
         s = s - {1'b0, FIELD_P};
      end
      return s[60:0];
   endfunction

   // full product, then two folds at bit 61 and a final subtract
   function automatic logic [60:0] mod_mul(input logic [60:0] x, input logic [60:0] y);
      logic [121:0] prod;
      logic [61:0]  t;
      prod = 122'(x) * 122'(y);
      t = {1'b0, prod[121:61]} + {1'b0, prod[60:0]};
      t = {61'd0, t[61]} + {1'b0, t[60:0]};
      if (t >= {1'b0, FIELD_P}) begin
         t = t - {1'b0, FIELD_P};
      end
      return t[60:0];
   endfunction

   // square and multiply from the low exponent bit
   function automatic logic [60:0] mod_pow(input logic [60:0] base, input logic [63:0] power);
      logic [60:0] acc;
      logic [60:0] sq;
      acc = 61'd1;
      sq  = base;
      for (int i = 0; i < 64; i++) begin
         if (power[i]) begin
            acc = mod_mul(acc, sq);
         end
         sq = mod_mul(sq, sq);
      end
      return acc;
   endfunction

   function automatic logic [60:0] alu_outcome(
      input logic [2:0]  code,
      input logic [60:0] a_in,
      input logic [60:0] b_in,
      input logic [63:0] power
   );
      logic [60:0] a;
      logic [60:0] b;
      logic [60:0] r;
      a = canon(a_in);
      b = canon(b_in);
      case (code)
         OP_ADD:  r = mod_add(a, b);
         OP_SUB:  r = mod_add(a, FIELD_P - b);
         OP_MUL:  r = mod_mul(a, b);
         OP_NEG:  r = mod_add('0, FIELD_P - a);
         OP_POW:  r = mod_pow(a, power);
         OP_INV:  r = mod_pow(a, INV_POWER);
         OP_DIV:  r = mod_mul(a, mod_pow(b, INV_POWER));
         default: r = '0;
      endcase
      return r;
   endfunction

   initial begin
      mismatch_count = 0;
      compared_count = 0;
      awaited_count  = 0;
   end

   // retire the response beat first, then queue the prediction for a request beat
   always @(posedge clock) begin
      logic [60:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected rsp beat: rsp_result expected none actual %h", rsp_result);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               compared_count++;
               if (rsp_result !== want) begin
                  $error("rsp_result mismatch: expected %h actual %h", want, rsp_result);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(
               alu_outcome(req_type, req_operand_a, req_operand_b, req_exponent));
         end
         awaited_count = pending_results.size();
      end
   end

endmodule

### dv/mersenne61_modular_alu_tb.sv
// testbench top for the mod 2^61-1 alu: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module mersenne61_modular_alu_tb;
   import m61_pkg::*;

   // opcode with no operation behind it
   localparam logic [2:0]  OP_SPARE  = 3'd7;
   localparam logic [60:0] P_MINUS_1 = FIELD_P - 61'd1;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type      = '0;
   logic [60:0] req_operand_a = '0;
   logic [60:0] req_operand_b = '0;
   logic [63:0] req_exponent  = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [60:0] rsp_result;

   int mismatch_count;
   int compared_count;
   int awaited_count;
   int sent_count = 0;
   int per_op [8];
   bit quiet      = 1'b0;
   bit hold_done  = 1'b0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mersenne61_modular_alu dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_exponent  (req_exponent),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   m61_result_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_exponent   (req_exponent),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result     (rsp_result),
      .mismatch_count (mismatch_count),
      .compared_count (compared_count),
      .awaited_count  (awaited_count)
   );

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int sel;
      sel = $urandom_range(0, 99);
      if (quiet || sel < 55) begin
         return 0;
      end else if (sel < 90) begin
         return $urandom_range(1, 3);
      end else if (sel < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // operands near both ends of the field, the unreduced pattern, single-bit values and plain random
   function automatic logic [60:0] pick_operand();
      int          sel;
      logic [60:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
         v = 61'({$urandom, $urandom});
      end else if (sel < 75) begin
         v = 61'($urandom_range(0, 15));
      end else if (sel < 85) begin
         v = FIELD_P - 61'($urandom_range(1, 16));
      end else if (sel < 90) begin
         v = FIELD_P;
      end else begin
         v = 61'd1 << $urandom_range(0, 60);
      end
      return v;
   endfunction

   // exponents of every bit length, short ones favored to keep power quick
   function automatic logic [63:0] pick_exponent();
      int          sel;
      logic [63:0] e;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         e = 64'($urandom_range(0, 40));
      end else if (sel < 80) begin
         e = {$urandom, $urandom} >> $urandom_range(0, 63);
      end else if (sel < 90) begin
         e = '1;
      end else begin
         e = 64'd1 << $urandom_range(0, 63);
      end
      return e;
   endfunction

   // offer one request beat after an optional gap and hold it until taken
   task automatic send_beat(
      input logic [2:0]  code,
      input logic [60:0] a,
      input logic [60:0] b,
      input logic [63:0] power
   );
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= code;
      req_operand_a <= a;
      req_operand_b <= b;
      req_exponent  <= power;
      do @(posedge clock); while (req_stall);
      sent_count++;
      per_op[code]++;
   endtask

   // response side: random stall runs, plus one long hold-off to back the unit up
   initial begin
      int hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && sent_count >= 250) begin
            hold      = 400;
            hold_done = 1'b1;
         end else begin
            hold = gap_len();
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // request stimulus and verdict
   initial begin
      logic [2:0] code;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every opcode and the corner cases
      send_beat(OP_ADD, P_MINUS_1, P_MINUS_1, '0);
      send_beat(OP_ADD, '0, '0, '1);
      send_beat(OP_ADD, FIELD_P, 61'd5, '0);
      send_beat(OP_SUB, '0, P_MINUS_1, '0);
      send_beat(OP_SUB, 61'd5, 61'd5, '0);
      send_beat(OP_SUB, 61'd3, FIELD_P, '0);
      send_beat(OP_MUL, P_MINUS_1, P_MINUS_1, '0);
      send_beat(OP_MUL, 61'h1555_5555_5555_5555, 61'h0AAA_AAAA_AAAA_AAAA, '0);
      send_beat(OP_MUL, '0, P_MINUS_1, '0);
      send_beat(OP_MUL, 61'h1FFF_FFFF_8000_0000, 61'h0000_0000_7FFF_FFFF, '0);
      send_beat(OP_NEG, '0, '0, '0);
      send_beat(OP_NEG, P_MINUS_1, '0, '0);
      send_beat(OP_NEG, FIELD_P, '0, '0);
      send_beat(OP_POW, '0, '0, '0);
      send_beat(OP_POW, 61'd7, '0, '0);
      send_beat(OP_POW, P_MINUS_1, '0, '1);
      send_beat(OP_POW, 61'd2, '0, 64'd61);
      send_beat(OP_POW, FIELD_P, '0, 64'd5);
      send_beat(OP_INV, '0, '0, '0);
      send_beat(OP_INV, 61'd1, '0, '0);
      send_beat(OP_INV, P_MINUS_1, '0, '0);
      send_beat(OP_DIV, 61'd10, '0, '0);
      send_beat(OP_DIV, '0, 61'd7, '0);
      send_beat(OP_DIV, P_MINUS_1, 61'd3, '0);
      send_beat(OP_SPARE, pick_operand(), pick_operand(), '1);

      // random: spare opcode now and then, a back-to-back stretch in the middle
      for (int n = 0; n < 675; n++) begin
         quiet = (n >= 400 && n < 500);
         code  = ($urandom_range(0, 99) < 4) ? OP_SPARE : 3'($urandom_range(0, 6));
         send_beat(code, pick_operand(), pick_operand(), pick_exponent());
      end
      req_valid <= 1'b0;

      // drain, then allow the longest power latency for stray beats
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("requests sent %0d: add %0d sub %0d mul %0d neg %0d pow %0d",
               sent_count, per_op[0], per_op[1], per_op[2], per_op[3], per_op[4]);
      $display("   inv %0d div %0d spare %0d", per_op[5], per_op[6], per_op[7]);
      $display("results compared %0d, mismatches %0d, long response hold-off applied %0d",
               compared_count, mismatch_count, hold_done);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #15ms;
      $display("status: fail");
      $finish;
   end

endmodule
